/* sv/bpe_ptk_pkg.sv */
// ----------------------------------------------------------------------------
// bpe_ptk_pkg
// shared types and constants for the pre-tokenizer chunk marker
// ----------------------------------------------------------------------------
package bpe_ptk_pkg;

    // kind of the chunk a byte starts or continues
    typedef enum logic [2:0] {
        KIND_CONTRACTION = 3'd0,
        KIND_LETTERS     = 3'd1,
        KIND_DIGITS      = 3'd2,
        KIND_NEWLINES    = 3'd3,
        KIND_SPACES      = 3'd4,
        KIND_PUNCT       = 3'd5
    } chunk_kind_t;

    // open chunk: kind, sub-phase, contraction bytes left or digits taken
    typedef struct packed {
        chunk_kind_t kind;
        logic        phase;
        logic [1:0]  run_count;
    } chunk_state_t;

    // outcome of classifying one byte
    typedef struct packed {
        logic         starts_chunk;
        chunk_state_t next_state;
    } class_result_t;

    localparam chunk_state_t CHUNK_IDLE = '{kind: KIND_CONTRACTION, phase: 1'b0,
                                            run_count: 2'd0};

    localparam logic [1:0] DIGIT_RUN_LIMIT = 2'd3;
    localparam logic [1:0] LOOKAHEAD_FULL  = 2'd2;

endpackage

/* sv/bpe_ptk_classify.sv */
// ----------------------------------------------------------------------------
// bpe_ptk_classify
// decides whether one byte opens a chunk, given the open chunk and lookahead
// ----------------------------------------------------------------------------
module bpe_ptk_classify #(
    parameter logic [1:0] DIGIT_LIMIT = bpe_ptk_pkg::DIGIT_RUN_LIMIT
) (
    input  logic [7:0]                  byte0,
    input  logic [1:0]                  avail,
    input  logic [7:0]                  byte1,
    input  logic [7:0]                  byte2,
    input  bpe_ptk_pkg::chunk_state_t   state_in,
    output bpe_ptk_pkg::class_result_t  result
);
    import bpe_ptk_pkg::*;

    localparam logic [7:0] APOSTROPHE = 8'h27;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_M     = 8'h6d;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_E     = 8'h65;
    localparam logic [7:0] CHAR_V     = 8'h76;
    localparam logic [7:0] CHAR_L     = 8'h6c;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_nl(input logic [7:0] c);
        return c == 8'h0a || c == 8'h0d;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d ||
               c == 8'h0c || c == 8'h0b;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return !is_letter(c) && !is_digit(c) && !is_ws(c);
    endfunction

    logic         cont;
    chunk_state_t cont_state;
    chunk_state_t open_state;
    logic [7:0]   low1;
    logic [7:0]   low2;

    // does the open chunk take this byte
    always_comb begin
        cont       = 1'b0;
        cont_state = state_in;
        unique case (state_in.kind)
            KIND_CONTRACTION: begin
                if (state_in.run_count != 2'd0) begin
                    cont                 = 1'b1;
                    cont_state.run_count = state_in.run_count - 2'd1;
                end
            end
            KIND_LETTERS: begin
                if (!state_in.phase && is_letter(byte0)) begin
                    cont = 1'b1;
                end else if (byte0[7]) begin
                    cont             = 1'b1;
                    cont_state.phase = 1'b1;
                end
            end
            KIND_DIGITS: begin
                if (is_digit(byte0) && state_in.run_count < DIGIT_LIMIT) begin
                    cont                 = 1'b1;
                    cont_state.run_count = state_in.run_count + 2'd1;
                end
            end
            KIND_NEWLINES: cont = is_nl(byte0);
            KIND_SPACES:   cont = is_ws(byte0) && !is_nl(byte0);
            KIND_PUNCT: begin
                if (!state_in.phase && is_punct(byte0)) begin
                    cont = 1'b1;
                end else if (is_nl(byte0)) begin
                    cont             = 1'b1;
                    cont_state.phase = 1'b1;
                end
            end
            default: cont = 1'b0;
        endcase
    end

    // priority order for a new chunk
    always_comb begin
        low1       = byte1 | CASE_BIT;
        low2       = byte2 | CASE_BIT;
        open_state = CHUNK_IDLE;
        priority if (byte0 == APOSTROPHE && avail != 2'd0 &&
                     (low1 == CHAR_S || low1 == CHAR_T || low1 == CHAR_M ||
                      low1 == CHAR_D)) begin
            open_state.kind      = KIND_CONTRACTION;
            open_state.run_count = 2'd1;
        end else if (byte0 == APOSTROPHE && avail == LOOKAHEAD_FULL &&
                     ((low1 == CHAR_R && low2 == CHAR_E) ||
                      (low1 == CHAR_V && low2 == CHAR_E) ||
                      (low1 == CHAR_L && low2 == CHAR_L))) begin
            open_state.kind      = KIND_CONTRACTION;
            open_state.run_count = 2'd2;
        end else if (is_letter(byte0) ||
                     (is_punct(byte0) && avail != 2'd0 && is_letter(byte1))) begin
            open_state.kind = KIND_LETTERS;
        end else if (is_digit(byte0)) begin
            open_state.kind      = KIND_DIGITS;
            open_state.run_count = 2'd1;
        end else if (is_nl(byte0)) begin
            open_state.kind = KIND_NEWLINES;
        end else if (is_ws(byte0)) begin
            open_state.kind = KIND_SPACES;
        end else begin
            open_state.kind = KIND_PUNCT;
        end
    end

    assign result.starts_chunk = !cont;
    assign result.next_state   = cont ? cont_state : open_state;

endmodule

/* sv/bpe_pretokenizer_chunk_marker.sv */
// ----------------------------------------------------------------------------
// bpe_pretokenizer_chunk_marker
// marks pre-tokenization chunk starts in a byte stream, two bytes of lookahead
// ----------------------------------------------------------------------------
// Text enters one byte per item on the s_ channel and leaves on the m_ channel
// two items later, with a chunk start flag and the chunk kind. The first two
// bytes of a text produce no result; every later byte produces one, so the
// block sustains one item per cycle while the receiver keeps up and no flush
// runs. Each byte passes the input register and the lookahead window, then the
// classifier into the result register. A byte flagged end_of_text flushes the
// held bytes: that item gives up to three results, one per cycle while the
// receiver keeps up, and the input side stalls while the flush runs. run_last
// marks the final result of each item, text_end the final byte of the text,
// after which all chunk state returns to its reset value.
// ----------------------------------------------------------------------------
module bpe_pretokenizer_chunk_marker #(
    // longest digit run kept in one chunk
    parameter logic [1:0] DIGIT_LIMIT = bpe_ptk_pkg::DIGIT_RUN_LIMIT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_byte_value,
    input  logic                       s_end_of_text,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_starts_chunk,
    output bpe_ptk_pkg::chunk_kind_t   m_chunk_kind,
    output logic                       m_text_end,
    output logic                       m_run_last
);
    import bpe_ptk_pkg::*;

    // input register
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg,  in_byte_next;
    logic         in_eot_reg,   in_eot_next;

    // lookahead window, plus a third slot used only while flushing
    logic [7:0]   hold0_reg, hold0_next;
    logic [7:0]   hold1_reg, hold1_next;
    logic [7:0]   hold2_reg, hold2_next;
    logic [1:0]   pend_reg,  pend_next;     // bytes held in normal flow
    logic [1:0]   flush_reg, flush_next;    // results left in a flush
    chunk_state_t chunk_reg, chunk_next;

    // result register
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_byte_reg,  out_byte_next;
    logic         out_start_reg, out_start_next;
    chunk_kind_t  out_kind_reg,  out_kind_next;
    logic         out_end_reg,   out_end_next;
    logic         out_last_reg,  out_last_next;

    logic          out_free;
    logic          flushing;
    logic          flush_step;
    logic          normal_emit;
    logic          in_take;
    logic          flush_final;
    logic [7:0]    cls_byte2;
    logic [1:0]    cls_avail;
    class_result_t cls_result;

    assign out_free    = !out_valid_reg || m_ready;
    assign flushing    = flush_reg != 2'd0;
    assign flush_step  = flushing && out_free;
    assign flush_final = flush_reg == 2'd1;
    // full window: oldest byte leaves on a new byte once the result reg frees
    assign normal_emit = in_valid_reg && !flushing && !in_eot_reg &&
                         pend_reg == LOOKAHEAD_FULL && out_free;
    assign in_take     = in_valid_reg && !flushing &&
                         (in_eot_reg || pend_reg != LOOKAHEAD_FULL || out_free);
    assign s_ready     = !in_valid_reg || in_take;

    // in normal flow the incoming byte is the second lookahead byte
    assign cls_byte2 = flushing ? hold2_reg : in_byte_reg;
    assign cls_avail = flushing ? flush_reg - 2'd1 : LOOKAHEAD_FULL;

    bpe_ptk_classify #(
        .DIGIT_LIMIT (DIGIT_LIMIT)
    ) u_classify (
        .byte0    (hold0_reg),
        .avail    (cls_avail),
        .byte1    (hold1_reg),
        .byte2    (cls_byte2),
        .state_in (chunk_reg),
        .result   (cls_result)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_eot_next    = in_eot_reg;
        hold0_next     = hold0_reg;
        hold1_next     = hold1_reg;
        hold2_next     = hold2_reg;
        pend_next      = pend_reg;
        flush_next     = flush_reg;
        chunk_next     = chunk_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_start_next = out_start_reg;
        out_kind_next  = out_kind_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;

        // input register
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_byte_value;
            in_eot_next   = s_end_of_text;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end

        // one result per cycle into the result register, while it is free
        if (flush_step || normal_emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = hold0_reg;
            out_start_next = cls_result.starts_chunk;
            out_kind_next  = cls_result.next_state.kind;
            out_end_next   = flushing && flush_final;
            out_last_next  = !flushing || flush_final;
            chunk_next     = cls_result.next_state;
            hold0_next     = hold1_reg;
        end

        if (flush_step) begin
            hold1_next = hold2_reg;
            flush_next = flush_reg - 2'd1;
            // text done, next byte opens a fresh text
            if (flush_final) begin
                chunk_next = CHUNK_IDLE;
            end
        end else if (normal_emit) begin
            hold1_next = in_byte_reg;
        end else if (in_take) begin
            // warm-up or end of text: park the byte in the next free slot
            unique case (pend_reg)
                2'd0:    hold0_next = in_byte_reg;
                2'd1:    hold1_next = in_byte_reg;
                default: hold2_next = in_byte_reg;
            endcase
            if (in_eot_reg) begin
                flush_next = pend_reg + 2'd1;
                pend_next  = 2'd0;
            end else begin
                pend_next  = pend_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pend_reg      <= 2'd0;
            flush_reg     <= 2'd0;
            chunk_reg     <= CHUNK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            pend_reg      <= pend_next;
            flush_reg     <= flush_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        in_byte_reg   <= in_byte_next;
        in_eot_reg    <= in_eot_next;
        hold0_reg     <= hold0_next;
        hold1_reg     <= hold1_next;
        hold2_reg     <= hold2_next;
        out_byte_reg  <= out_byte_next;
        out_start_reg <= out_start_next;
        out_kind_reg  <= out_kind_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_starts_chunk = out_start_reg;
    assign m_chunk_kind   = out_kind_reg;
    assign m_text_end     = out_end_reg;
    assign m_run_last     = out_last_reg;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pre-tokenizer chunk marker
// ----------------------------------------------------------------------------
// A short table of directed text covers the byte extremes, every chunk kind,
// contractions with and without enough lookahead, leaders, high-byte tails and
// newline tails. Random texts built from words, contractions, digit, space,
// newline and punctuation runs, high bytes and plain noise follow. Every
// accepted item runs through a local model of the chunk marker; each result
// on the m_ channel is compared field by field with the oldest expectation.
// The sender works in bursts, the receiver stalls in its own patterns, and
// one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bpe_ptk_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int TAIL_CYCLES    = 10;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 100;
    localparam int DIRECTED_COUNT = 26;

    localparam logic [7:0] APOSTROPHE = 8'h27;

    // one result as it leaves the block
    typedef struct {
        logic [7:0]  text_byte;
        logic        starts;
        chunk_kind_t kind;
        logic        text_end;
        logic        run_last;
    } chunk_mark_t;

    // one input item, with an optional hand-typed first result
    typedef struct packed {
        logic [7:0]  text_byte;
        logic        eot;
        logic        has_typed;
        logic [7:0]  t_byte;
        logic        t_starts;
        chunk_kind_t t_kind;
        logic        t_end;
        logic        t_last;
    } text_item_t;

    // ports; every input that the bench drives starts known from time zero
    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value   = 8'h00;
    logic        s_end_of_text  = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_starts_chunk;
    chunk_kind_t m_chunk_kind;
    logic        m_text_end;
    logic        m_run_last;

    // local copy of the marker's state
    logic [7:0]  window [2]     = '{8'h00, 8'h00};
    int          window_fill    = 0;
    chunk_kind_t open_kind      = KIND_CONTRACTION;
    logic        open_phase     = 1'b0;
    logic [1:0]  open_run       = 2'd0;

    chunk_mark_t pending_marks [$];
    chunk_mark_t fresh_marks [$];

    int          fail_count     = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    bit          hold_req       = 1'b0;
    logic [7:0]  text_q [$];

    string       punct_set      = "!\"#$%&()*+,-./:;<=>?@[\\]^_`{|}~";

    // directed text: extremes, every kind, contraction corners, tails
    text_item_t directed_rows [DIRECTED_COUNT] = '{
        // single letter right after reset, flushed at once
        '{"a",   1'b1, 1'b1, "a",   1'b1, KIND_LETTERS,     1'b1, 1'b1},
        // byte extremes: 0x00 leads nothing, 0xff joins the punctuation run
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{8'hff, 1'b1, 1'b1, 8'h00, 1'b1, KIND_PUNCT,       1'b0, 1'b0},
        // 's then a letter
        '{"'",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"s",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"X",   1'b1, 1'b1, "'",   1'b1, KIND_CONTRACTION, 1'b0, 1'b0},
        // upper-case 're, the two-byte contraction
        '{"'",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"R",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"e",   1'b0, 1'b1, "'",   1'b1, KIND_CONTRACTION, 1'b0, 1'b1},
        '{" ",   1'b1, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        // 'l at end of text: second byte missing, becomes a letter leader
        '{"'",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"L",   1'b1, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        // four digits split after three, then a newline
        '{"1",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"2",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"3",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"4",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"\n",  1'b1, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        // space run stops at the newline
        '{"\t",  1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{" ",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{8'h0d, 1'b1, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        // punctuation with a newline tail, then punctuation again
        '{".",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{"\n",  1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        // letters with a high-byte tail
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0},
        '{8'hc3, 1'b1, 1'b0, 8'h00, 1'b0, KIND_CONTRACTION, 1'b0, 1'b0}
    };

    bpe_pretokenizer_chunk_marker DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_starts_chunk (m_starts_chunk),
        .m_chunk_kind   (m_chunk_kind),
        .m_text_end     (m_text_end),
        .m_run_last     (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // queue appends
    function automatic void add_text_byte(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void add_fresh_mark(chunk_mark_t m);
        fresh_marks.insert(fresh_marks.size(), m);
    endfunction

    function automatic void add_pending_mark(chunk_mark_t m);
        pending_marks.insert(pending_marks.size(), m);
    endfunction

    // byte classes
    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_newline(logic [7:0] c);
        return c == 8'h0a || c == 8'h0d;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d
            || c == 8'h0c || c == 8'h0b;
    endfunction

    function automatic bit is_symbol(logic [7:0] c);
        return !is_letter(c) && !is_digit(c) && !is_space(c);
    endfunction

    // does the open chunk swallow this byte; advances its sub-state if so
    function automatic bit chunk_extends(logic [7:0] c);
        case (open_kind)
            KIND_CONTRACTION: begin
                if (open_run != 2'd0) begin
                    open_run = open_run - 2'd1;
                    return 1'b1;
                end
                return 1'b0;
            end
            KIND_LETTERS: begin
                if (!open_phase && is_letter(c)) return 1'b1;
                if (c >= 8'h80) begin
                    open_phase = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            KIND_DIGITS: begin
                if (is_digit(c) && open_run < DIGIT_RUN_LIMIT) begin
                    open_run = open_run + 2'd1;
                    return 1'b1;
                end
                return 1'b0;
            end
            KIND_NEWLINES: return is_newline(c);
            KIND_SPACES:   return is_space(c) && !is_newline(c);
            KIND_PUNCT: begin
                if (!open_phase && is_symbol(c)) return 1'b1;
                if (is_newline(c)) begin
                    open_phase = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // decide the chunk of b0 given how many following bytes are known
    function automatic chunk_mark_t mark_byte(logic [7:0] b0, int ahead, logic [7:0] b1,
                                              logic [7:0] b2, logic fin);
        chunk_mark_t r;
        logic [7:0]  n1;
        logic [7:0]  n2;
        r.text_byte = b0;
        r.text_end  = fin;
        r.run_last  = fin;
        r.starts    = 1'b1;
        n1 = b1 | 8'h20;
        n2 = b2 | 8'h20;
        if (chunk_extends(b0)) begin
            r.starts = 1'b0;
        end else begin
            open_phase = 1'b0;
            open_run   = 2'd0;
            if (b0 == APOSTROPHE && ahead >= 1
                    && (n1 == "s" || n1 == "t" || n1 == "m" || n1 == "d")) begin
                open_kind = KIND_CONTRACTION;
                open_run  = 2'd1;
            end else if (b0 == APOSTROPHE && ahead >= 2
                    && ((n1 == "r" && n2 == "e") || (n1 == "v" && n2 == "e")
                        || (n1 == "l" && n2 == "l"))) begin
                open_kind = KIND_CONTRACTION;
                open_run  = 2'd2;
            end else if (is_letter(b0) || (is_symbol(b0) && ahead >= 1 && is_letter(b1))) begin
                open_kind = KIND_LETTERS;
            end else if (is_digit(b0)) begin
                open_kind = KIND_DIGITS;
                open_run  = 2'd1;
            end else if (is_newline(b0)) begin
                open_kind = KIND_NEWLINES;
            end else if (is_space(b0)) begin
                open_kind = KIND_SPACES;
            end else begin
                open_kind = KIND_PUNCT;
            end
        end
        r.kind = open_kind;
        return r;
    endfunction

    // results caused by one accepted byte go to fresh_marks
    task automatic predict_marks(input logic [7:0] b, input logic eot);
        logic [7:0] pend [5];
        int         n;
        fresh_marks.delete();
        if (!eot) begin
            if (window_fill >= 2) begin
                // steady state: oldest byte leaves with two bytes of lookahead
                add_fresh_mark(mark_byte(window[0], 2, window[1], b, 1'b0));
                fresh_marks[0].run_last = 1'b1;
                window[0] = window[1];
                window[1] = b;
            end else begin
                // warm-up, nothing leaves yet
                window[window_fill] = b;
                window_fill++;
            end
        end else begin
            // flush: held bytes and this one, lookahead shrinking at the end
            pend = '{default: 8'h00};
            n = window_fill;
            for (int k = 0; k < n; k++) pend[k] = window[k];
            pend[n] = b;
            n++;
            for (int k = 0; k < n; k++)
                add_fresh_mark(mark_byte(pend[k], n - 1 - k, pend[k + 1], pend[k + 2],
                                         k + 1 == n));
            window      = '{8'h00, 8'h00};
            window_fill = 0;
            open_kind   = KIND_CONTRACTION;
            open_phase  = 1'b0;
            open_run    = 2'd0;
        end
    endtask

    // offer one item, wait for the handshake, record its results, maybe idle
    task automatic send_item(input text_item_t item);
        chunk_mark_t m;
        s_valid       <= 1'b1;
        s_byte_value  <= item.text_byte;
        s_end_of_text <= item.eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_marks(item.text_byte, item.eot);
        foreach (fresh_marks[k]) begin
            m = fresh_marks[k];
            if (k == 0 && item.has_typed) begin
                // hand-typed first result takes the place of the model's
                m.text_byte = item.t_byte;
                m.starts    = item.t_starts;
                m.kind      = item.t_kind;
                m.text_end  = item.t_end;
                m.run_last  = item.t_last;
            end
            add_pending_mark(m);
        end
        // bursts with gaps, but keep pushing while the receiver holds off
        if (hold_req) begin
            burst_left = 0;
        end else if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    // idle the input until the block has handed back everything expected
    task automatic drain_marks();
        s_valid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] any_case(logic [7:0] c);
        return $urandom_range(0, 1) ? (c & 8'hdf) : c;
    endfunction

    function automatic logic [7:0] pick_symbol();
        return punct_set[$urandom_range(0, punct_set.len() - 1)];
    endfunction

    // one random text into text_q, mostly well-formed tokens
    task automatic build_text();
        int          n;
        int          sel;
        logic [7:0]  pair [7][2];
        pair = '{'{"s", 8'h00}, '{"t", 8'h00}, '{"m", 8'h00}, '{"d", 8'h00},
                 '{"r", "e"}, '{"v", "e"}, '{"l", "l"}};
        text_q.delete();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1, 9: begin
                    // word, sometimes with a symbol leader or a high tail
                    if ($urandom_range(0, 3) == 0) add_text_byte(pick_symbol());
                    repeat ($urandom_range(1, 6))
                        add_text_byte(any_case(8'h61 + 8'($urandom_range(0, 25))));
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2))
                            add_text_byte(8'($urandom_range(128, 255)));
                end
                2: begin
                    // contraction, now and then broken on its second byte
                    sel = $urandom_range(0, 6);
                    add_text_byte(APOSTROPHE);
                    add_text_byte(any_case(pair[sel][0]));
                    if (sel >= 4)
                        add_text_byte($urandom_range(0, 4) == 0
                                      ? any_case(8'h61 + 8'($urandom_range(0, 25)))
                                      : any_case(pair[sel][1]));
                end
                3: repeat ($urandom_range(1, 5)) add_text_byte(8'h30 + 8'($urandom_range(0, 9)));
                4: begin
                    repeat ($urandom_range(1, 3)) begin
                        sel = $urandom_range(0, 3);
                        add_text_byte(sel == 0 ? 8'h20 : sel == 1 ? 8'h09 :
                                      sel == 2 ? 8'h0c : 8'h0b);
                    end
                end
                5: repeat ($urandom_range(1, 2))
                       add_text_byte($urandom_range(0, 1) ? 8'h0a : 8'h0d);
                6: begin
                    repeat ($urandom_range(1, 3)) add_text_byte(pick_symbol());
                    if ($urandom_range(0, 1)) add_text_byte(8'h0a);
                end
                7: repeat ($urandom_range(1, 2)) add_text_byte(8'($urandom_range(128, 255)));
                default: repeat ($urandom_range(1, 2)) add_text_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // receiver: segments of its own stall patterns, one long hold-off on request
    initial begin
        int mode;
        int seg;
        int tick;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(10, 50);
            repeat (seg) begin
                if (hold_req) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        default: m_ready <= (tick % 4) != 3;
                    endcase
                    tick++;
                    @(posedge aclk);
                end
            end
        end
    end

    // result checker against the oldest expectation
    always @(posedge aclk) begin
        chunk_mark_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_marks.size() == 0) begin
                $error("unexpected result: out_byte %h", m_out_byte);
                fail_count++;
            end else begin
                e = pending_marks.pop_front();
                if (m_out_byte !== e.text_byte) begin
                    $error("out_byte: expected %h, actual %h", e.text_byte, m_out_byte);
                    fail_count++;
                end
                if (m_starts_chunk !== e.starts) begin
                    $error("starts_chunk: expected %0d, actual %0d", e.starts, m_starts_chunk);
                    fail_count++;
                end
                if (m_chunk_kind !== e.kind) begin
                    $error("chunk_kind: expected %0d, actual %0d", e.kind, m_chunk_kind);
                    fail_count++;
                end
                if (m_text_end !== e.text_end) begin
                    $error("text_end: expected %0d, actual %0d", e.text_end, m_text_end);
                    fail_count++;
                end
                if (m_run_last !== e.run_last) begin
                    $error("run_last: expected %0d, actual %0d", e.run_last, m_run_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("bpe_pretokenizer_chunk_marker verification failed");
        $finish;
    end

    // stimulus
    initial begin
        text_item_t item;
        int         random_sent;
        bit         paused;
        random_sent = 0;
        paused      = 1'b0;
        item        = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < DIRECTED_COUNT; i++) send_item(directed_rows[i]);
        drain_marks();

        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;

        // random texts, each closed by end_of_text
        while (random_sent < RANDOM_ITEMS) begin
            build_text();
            foreach (text_q[k]) begin
                item.text_byte = text_q[k];
                item.eot       = (k == text_q.size() - 1);
                send_item(item);
            end
            random_sent += text_q.size();
            if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_marks();
            end
        end

        drain_marks();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("bpe_pretokenizer_chunk_marker verification clean");
        end else begin
            $display("bpe_pretokenizer_chunk_marker verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/bpe_ptk_pkg.sv
sv/bpe_ptk_classify.sv
sv/bpe_pretokenizer_chunk_marker.sv
tb/tb.sv
